[design/rmed_pkg.sv]
// Package: shared types and constants for the running median unit.
package rmed_pkg;

    localparam int SAMPLE_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_MED_A,
        ST_MED_B,
        ST_OUT
    } rmed_state_t;

    typedef struct packed {
        logic               rd_en;
        logic               wr_en;
        logic signed [SAMPLE_W-1:0] wr_data;
    } rmed_mem_ctl_t;

endpackage

[design/running_median_unit.sv]
// Top level: running median of a signed 32-bit stream over a sorted memory.
// One word is taken at a time. The unit scans the sorted store from the top
// down, reading one entry per cycle and moving each entry larger than the new
// sample up by one place, then writes the sample into the gap and reads the one
// or two middle entries. An empty store skips the scan, and a full store skips
// the scan and the write and reads the middle entries at once. The single read
// port of the store limits the scan to one entry at a time. The result sits in
// an output register, and the next word is accepted only once it has been taken.
module running_median_unit #(
    parameter int CAPACITY = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] sample
    input  logic        s_tlast,   // end_of_stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] median
    output logic        m_tuser    // full_res
);
    import rmed_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    rmed_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic signed [SAMPLE_W-1:0] x_reg, x_next;
    logic last_reg, last_next;
    logic full_reg, full_next;
    logic signed [SAMPLE_W-1:0] a_reg, a_next;
    logic signed [SAMPLE_W-1:0] med_reg, med_next;
    logic mvalid_reg, mvalid_next;

    rmed_mem_ctl_t ctl;
    logic [AW-1:0] rd_addr, wr_addr;
    logic signed [SAMPLE_W-1:0] rd_data;

    logic [CW-1:0] mid_hi;
    logic signed [SAMPLE_W:0] sum33;
    logic signed [SAMPLE_W:0] half33;

    rmed_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
        .clk     (clk),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        x_reg    <= x_next;
        last_reg <= last_next;
        full_reg <= full_next;
        a_reg    <= a_next;
        med_reg  <= med_next;
    end

    // new count after insert: mid_hi = count/2 index
    assign mid_hi = count_reg >> 1;
    assign sum33  = {a_reg[SAMPLE_W-1], a_reg} + {rd_data[SAMPLE_W-1], rd_data};
    assign half33 = (sum33 + {{SAMPLE_W{1'b0}}, sum33[SAMPLE_W]}) >>> 1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !mvalid_reg)
                begin
                    if (count_reg == CW'(CAPACITY))
                        state_next = ST_MED_A;
                    else if (count_reg == '0)
                        state_next = ST_SHIFT;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // rd_data = entry pos_reg-1
                if (rd_data <= x_reg || pos_reg == CW'(1))
                    state_next = ST_SHIFT;
            end
            ST_SHIFT: state_next = ST_MED_A;
            ST_MED_A: state_next = ST_MED_B;
            ST_MED_B: state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        x_next      = x_reg;
        last_next   = last_reg;
        full_next   = full_reg;
        a_next      = a_reg;
        med_next    = med_reg;
        mvalid_next = mvalid_reg;
        ctl.rd_en   = 1'b0;
        ctl.wr_en   = 1'b0;
        ctl.wr_data = x_reg;
        rd_addr     = '0;
        wr_addr     = '0;
        if (mvalid_reg && m_tready)
            mvalid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && !mvalid_reg)
                begin
                    x_next    = s_tdata;
                    last_next = s_tlast;
                    full_next = (count_reg == CW'(CAPACITY));
                    pos_next  = count_reg;
                    ctl.rd_en = 1'b1;
                    rd_addr   = AW'(count_reg - CW'(1));
                end
            end
            ST_SCAN:
            begin
                if (rd_data > x_reg)
                begin
                    ctl.wr_en   = 1'b1;
                    ctl.wr_data = rd_data;
                    wr_addr     = AW'(pos_reg);
                    pos_next    = pos_reg - CW'(1);
                    ctl.rd_en   = 1'b1;
                    rd_addr     = AW'(pos_reg - CW'(2));
                end
            end
            ST_SHIFT:
            begin
                ctl.wr_en  = 1'b1;
                wr_addr    = AW'(pos_reg);
                count_next = count_reg + CW'(1);
            end
            ST_MED_A:
            begin
                ctl.rd_en = 1'b1;
                rd_addr   = count_reg[0] ? AW'(mid_hi) : AW'(mid_hi - CW'(1));
            end
            ST_MED_B:
            begin
                a_next    = rd_data;
                ctl.rd_en = 1'b1;
                rd_addr   = AW'(mid_hi);
            end
            ST_OUT:
            begin
                med_next    = count_reg[0] ? rd_data : half33[SAMPLE_W-1:0];
                mvalid_next = 1'b1;
                if (last_reg)
                    count_next = '0;
            end
            default: ;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE) && !mvalid_reg;
        m_tvalid = mvalid_reg;
        m_tdata  = med_reg;
        m_tuser  = full_reg;
    end

endmodule

[design/rmed_store.sv]
// Sorted sample store: single-port-write, registered read memory.
module rmed_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                          clk,
    input  rmed_pkg::rmed_mem_ctl_t       ctl,
    input  logic [AW-1:0]                 rd_addr,
    input  logic [AW-1:0]                 wr_addr,
    output logic signed [rmed_pkg::SAMPLE_W-1:0] rd_data
);
    import rmed_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= ctl.wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[tb/sv/running_median_unit_tb.sv]
// Testbench for the running median unit: queued stimulus, sorted-store predictor, stream checks.
module running_median_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 1024;
    localparam int LIMIT_CYCLES = 20000000;

    typedef struct packed {
        logic signed [31:0] sample;
        logic               eos;
    } sample_word_t;

    typedef struct packed {
        logic signed [31:0] median;
        logic               full;
    } median_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;

    running_median_unit #(.CAPACITY(CAP)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    sample_word_t       pending_q[$];
    median_word_t       median_q[$];
    logic signed [31:0] sorted_vals[CAP];
    int unsigned        stored_n;
    int                 errors;
    int                 words_in;
    int                 words_out;
    int                 full_seen;
    int                 send_wait;
    int                 recv_wait;
    int                 hold_cycles;
    longint             cycles;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic median_word_t predict_median(sample_word_t w);
        median_word_t r;
        int unsigned  p;
        logic signed [32:0] sum;
        r.full = (stored_n >= CAP);
        if (!r.full)
        begin
            p = stored_n;
            while (p > 0 && sorted_vals[p-1] > w.sample)
            begin
                sorted_vals[p] = sorted_vals[p-1];
                p--;
            end
            sorted_vals[p] = w.sample;
            stored_n++;
        end
        if (stored_n[0])
            r.median = sorted_vals[(stored_n - 1) / 2];
        else
        begin
            sum = {sorted_vals[stored_n/2-1][31], sorted_vals[stored_n/2-1]}
                + {sorted_vals[stored_n/2][31], sorted_vals[stored_n/2]};
            if (sum < 0)
                sum = sum + 33'sd1;
            r.median = sum[32:1];
        end
        if (w.eos)
            stored_n = 0;
        return r;
    endfunction

    function automatic logic [31:0] rand_sample(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 15) - 8;
            2: return $urandom_range(0, 1) ? 32'h7fff_fff0 + $urandom_range(0, 15)
                                            : 32'h8000_0000 + $urandom_range(0, 15);
            default: return $urandom_range(0, 1000);
        endcase
    endfunction

    task automatic push_word(logic [31:0] s, logic e);
        sample_word_t w;
        w.sample = s;
        w.eos = e;
        pending_q.insert(pending_q.size(), w);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            send_wait <= 0;
        end
        else if (s_tvalid && !s_tready)
        begin
        end
        else
        begin
            if (s_tvalid)
            begin
                median_q.insert(median_q.size(), predict_median({s_tdata, s_tlast}));
                words_in <= words_in + 1;
            end
            if (send_wait > 0)
            begin
                s_tvalid <= 1'b0;
                send_wait <= send_wait - 1;
            end
            else if (pending_q.size() > 0)
            begin
                s_tvalid <= 1'b1;
                {s_tdata, s_tlast} <= pending_q.pop_front();
                send_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // monitor and receiver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                words_out <= words_out + 1;
                if (median_q.size() == 0)
                begin
                    $display("%0t: unexpected word median=%0d full=%0b",
                             $time, $signed(m_tdata), m_tuser);
                    errors <= errors + 1;
                end
                else
                begin
                    if (m_tuser)
                        full_seen <= full_seen + 1;
                    if (m_tdata !== median_q[0].median || m_tuser !== median_q[0].full)
                    begin
                        $display("%0t: mismatch expected median=%0d full=%0b",
                                 $time, median_q[0].median, median_q[0].full,
                                 " actual median=%0d full=%0b",
                                 $signed(m_tdata), m_tuser);
                        errors <= errors + 1;
                    end
                    void'(median_q.pop_front());
                end
            end
            if (hold_cycles > 0)
                m_tready <= 1'b0;
            else if (recv_wait > 0)
            begin
                m_tready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end
            else
            begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    recv_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
            end
        end
    end

    // long receiver hold-off after a while
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_cycles <= 0;
        else if (cycles == 3000)
            hold_cycles <= 400;
        else if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int n;
        int mode;
        errors = 0;
        words_in = 0;
        words_out = 0;
        full_seen = 0;
        stored_n = 0;
        cycles = 0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        push_word(32'h7fff_ffff, 1'b0);
        push_word(32'h7fff_ffff, 1'b0);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'h8000_0000, 1'b1);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'h8000_0001, 1'b0);
        push_word(32'hffff_ffff, 1'b0);
        push_word(32'h0000_0000, 1'b1);
        push_word(32'd5, 1'b0);
        push_word(32'd5, 1'b0);
        push_word(32'd5, 1'b0);
        push_word(-32'sd3, 1'b0);
        push_word(32'd2, 1'b1);
        push_word(-32'sd1, 1'b0);
        push_word(32'd0, 1'b1);
        push_word(32'h5555_5555, 1'b0);
        push_word(32'haaaa_aaaa, 1'b1);

        // fill the store: ascending keeps the scan short, then overflow and clear while full
        for (int i = 0; i < CAP; i++)
            push_word(i - 512, 1'b0);
        push_word(32'h7fff_ffff, 1'b0);
        push_word(32'h8000_0000, 1'b0);
        push_word(32'd7, 1'b1);

        n = 0;
        while (n < 300)
        begin
            int len;
            len = $urandom_range(1, 24);
            mode = $urandom_range(0, 3);
            for (int k = 0; k < len; k++)
            begin
                push_word(rand_sample(mode), (k == len - 1));
                n++;
            end
        end

        while (pending_q.size() != 0 || s_tvalid || median_q.size() != 0)
            @(posedge clk);
        repeat (CAP + 20) @(posedge clk);
        $display("Ran %0d words in, %0d out, %0d with a full store; long output stall included.",
                 words_in, words_out, full_seen);
        if (errors == 0 && median_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

[files.f]
design/rmed_pkg.sv
design/rmed_store.sv
design/running_median_unit.sv
tb/sv/running_median_unit_tb.sv
